// ----- src/mfd_pkg.sv -----
// Shared types and constants of the motor feedback decoder.
package mfd_pkg;

    // Register map, word index from paddr[3:2]
    localparam logic [1:0] REG_COUNTS_PER_TURN   = 2'd0;
    localparam logic [1:0] REG_SPEED_SMOOTHING   = 2'd1;
    localparam logic [1:0] REG_CURRENT_SMOOTHING = 2'd2;
    localparam logic [1:0] REG_OVERHEAT_LIMIT    = 2'd3;

    // Register reset values
    localparam logic [15:0] CPT_RESET    = 16'd8192;
    localparam logic [15:0] SMOOTH_RESET = 16'd32768;
    localparam logic [7:0]  LIMIT_RESET  = 8'd60;

    // Q1.15 unity weight and rounding offset
    localparam logic [15:0] Q15_ONE    = 16'h8000;
    localparam int          Q15_SHIFT  = 15;
    localparam int          ROUND_HALF = 16384;

    // Filter state widths in Q.8
    localparam int SPEED_W   = 27;
    localparam int CURRENT_W = 24;

    // Action codes
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Filter update control
    typedef struct packed {
        logic clr;
        logic upd;
    } mfd_filt_ctrl_t;

endpackage

// ----- src/mfd_filter.sv -----
// First-order smoothing filter with Q1.15 new-sample weight and Q.8 state.
module mfd_filter #(
    parameter int W = 27
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mfd_pkg::mfd_filt_ctrl_t ctrl,
    input  logic signed [W-1:0]     sample,
    input  logic [15:0]             weight,
    output logic signed [W-1:0]     state_next
);
    import mfd_pkg::*;

    logic signed [W-1:0]  state_reg;
    logic [15:0]          w_eff;
    logic signed [W:0]    diff;
    logic signed [W+17:0] prod;
    logic signed [W+17:0] rounded;
    logic signed [W+2:0]  step;
    logic signed [W-1:0]  filt_next;

    // Saturate the weight at one
    assign w_eff = (weight[15] && (|weight[14:0])) ? Q15_ONE : weight;

    // s + floor(((x - s) * w + half) / 2^15)
    assign diff    = {sample[W-1], sample} - {state_reg[W-1], state_reg};
    assign prod    = diff * $signed({1'b0, w_eff});
    assign rounded = prod + (W+18)'(ROUND_HALF);
    assign step    = rounded[W+17:Q15_SHIFT];
    assign filt_next = state_reg + step[W-1:0];

    // Select the next state
    always_comb
    begin
        if (ctrl.clr)
        begin
            state_next = '0;
        end
        else if (ctrl.upd)
        begin
            state_next = filt_next;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    // Hold the filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/motor_feedback_decoder.sv -----
// Motor feedback decoder top level: turn unwrap, smoothing filters, overheat stop.
//
// Usage: each transfer on s_axis carries one feedback frame (tuser = 0) or a
// clear request (tuser = 1). Every input transfer yields exactly one result
// transfer on m_axis with the multi-turn count, smoothed speed and current,
// and the stop and tracking flags in tuser.
// A result is registered: each input transfer passes the input register and
// then the result register before it appears on m_axis; the block takes one
// item per cycle while m_axis_tready stays high. The pipeline is an input
// register and a result register, with the state update in between.
// The APB port sets counts per turn, both smoothing weights and the overheat
// limit; write it only while no item is in flight.
// Reset clears the count, position and filters and marks the motor stopped;
// the first frame after reset or after a clear seeds the position, restarts
// the count at zero and releases the stop flag unless the temperature is over the limit.
// When m_axis_tready is low the result register holds and one more item is
// taken into the input register before s_axis_tready drops.
module motor_feedback_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] encoder_position, [31:16] speed_rpm, [47:32] current_raw,
    // [55:48] temperature
    input  logic [55:0] s_axis_tdata,
    // [0] action
    input  logic        s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] turn_count_total, [58:32] smoothed_speed, [82:59] smoothed_current,
    // [87:83] zero
    output logic [87:0] m_axis_tdata,
    // [0] motor_stopped, [1] tracking_valid
    output logic [1:0]  m_axis_tuser,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mfd_pkg::*;

    // Configuration registers
    logic [15:0] cpt_reg;
    logic [15:0] speed_w_reg;
    logic [15:0] current_w_reg;
    logic [7:0]  limit_reg;
    logic        cfg_write;

    // Input stage
    logic               in_valid_reg;
    logic               action_reg;
    logic [15:0]        pos_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] current_reg;
    logic [7:0]         temp_reg;

    // Measurement state
    logic [15:0] prev_reg;
    logic [15:0] prev_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        first_reg;
    logic        first_next;
    logic        stop_reg;
    logic        stop_next;

    // Result stage
    logic                         out_valid_reg;
    logic [31:0]                  count_out_reg;
    logic signed [SPEED_W-1:0]    speed_out_reg;
    logic signed [CURRENT_W-1:0]  current_out_reg;
    logic                         stopped_out_reg;
    logic                         tracking_out_reg;

    // Datapath
    logic                         advance;
    logic                         is_clear;
    logic                         is_frame;
    mfd_filt_ctrl_t               filt_ctrl;
    logic signed [SPEED_W-1:0]    speed_sample;
    logic signed [CURRENT_W-1:0]  current_sample;
    logic signed [SPEED_W-1:0]    speed_next;
    logic signed [CURRENT_W-1:0]  current_next;
    logic [15:0]                  prev_base;
    logic [31:0]                  acc_base;
    logic signed [17:0]           delta_raw;
    logic signed [17:0]           delta;
    logic signed [17:0]           cpt_s;
    logic signed [17:0]           half_s;

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_COUNTS_PER_TURN:   prdata = {16'd0, cpt_reg};
            REG_SPEED_SMOOTHING:   prdata = {16'd0, speed_w_reg};
            REG_CURRENT_SMOOTHING: prdata = {16'd0, current_w_reg};
            REG_OVERHEAT_LIMIT:    prdata = {24'd0, limit_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpt_reg       <= CPT_RESET;
            speed_w_reg   <= SMOOTH_RESET;
            current_w_reg <= SMOOTH_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_COUNTS_PER_TURN:   cpt_reg       <= pwdata[15:0];
                REG_SPEED_SMOOTHING:   speed_w_reg   <= pwdata[15:0];
                REG_CURRENT_SMOOTHING: current_w_reg <= pwdata[15:0];
                REG_OVERHEAT_LIMIT:    limit_reg     <= pwdata[7:0];
                default:               ;
            endcase
        end
    end

    // Pipeline flow: the input stage moves when the result stage is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            action_reg  <= s_axis_tuser;
            pos_reg     <= s_axis_tdata[15:0];
            speed_reg   <= s_axis_tdata[31:16];
            current_reg <= s_axis_tdata[47:32];
            temp_reg    <= s_axis_tdata[55:48];
        end
    end

    assign is_clear = advance && (action_reg == ACT_CLEAR);
    assign is_frame = advance && (action_reg == ACT_FRAME);

    // Filters: speed scaled by 6 to deg/s, both in Q.8
    assign speed_sample   = (SPEED_W'(speed_reg) <<< 10) + (SPEED_W'(speed_reg) <<< 9);
    assign current_sample = {current_reg, 8'd0};
    assign filt_ctrl.clr  = is_clear;
    assign filt_ctrl.upd  = is_frame;

    mfd_filter #(.W(SPEED_W)) u_speed_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (filt_ctrl),
        .sample     (speed_sample),
        .weight     (speed_w_reg),
        .state_next (speed_next)
    );

    mfd_filter #(.W(CURRENT_W)) u_current_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (filt_ctrl),
        .sample     (current_sample),
        .weight     (current_w_reg),
        .state_next (current_next)
    );

    // Unwrap the encoder delta by half a turn; the first frame seeds the position
    assign prev_base = first_reg ? prev_reg : pos_reg;
    assign acc_base  = first_reg ? acc_reg : 32'd0;
    assign delta_raw = $signed({2'b00, pos_reg}) - $signed({2'b00, prev_base});
    assign cpt_s     = $signed({2'b00, cpt_reg});
    assign half_s    = $signed({3'b000, cpt_reg[15:1]});

    always_comb
    begin
        if (delta_raw < -half_s)
        begin
            delta = delta_raw + cpt_s;
        end
        else if (delta_raw > half_s)
        begin
            delta = delta_raw - cpt_s;
        end
        else
        begin
            delta = delta_raw;
        end
    end

    // Next measurement state
    always_comb
    begin
        prev_next  = prev_reg;
        acc_next   = acc_reg;
        first_next = first_reg;
        stop_next  = stop_reg;
        if (is_clear)
        begin
            prev_next  = '0;
            acc_next   = '0;
            first_next = 1'b0;
        end
        else if (is_frame)
        begin
            prev_next  = pos_reg;
            acc_next   = acc_base + {{14{delta[17]}}, delta};
            first_next = 1'b1;
            stop_next  = (first_reg && stop_reg) || (temp_reg > limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            acc_reg   <= '0;
            first_reg <= 1'b0;
            stop_reg  <= 1'b1;
        end
        else
        begin
            prev_reg  <= prev_next;
            acc_reg   <= acc_next;
            first_reg <= first_next;
            stop_reg  <= stop_next;
        end
    end

    // Result register: load on advance, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            count_out_reg    <= acc_next;
            speed_out_reg    <= speed_next;
            current_out_reg  <= current_next;
            stopped_out_reg  <= stop_next;
            tracking_out_reg <= first_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, current_out_reg, speed_out_reg, count_out_reg};
    assign m_axis_tuser  = {tracking_out_reg, stopped_out_reg};

endmodule
